// ----- rtl/lbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_pkg: shared types and control store for the lcm sequencer
// micro-op and condition codes, the control word layout and the program rom
// ----------------------------------------------------------------------------
package lbe_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH       = 32;
  localparam int MULTIPLE_WIDTH    = 64;
  localparam int STEP_WIDTH        = 3;

  typedef logic [STEP_WIDTH-1:0] step_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_XY,
    OP_DIV_AX,
    OP_MUL,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_IN,
    CND_ZERO,
    CND_Y_ZERO,
    CND_DIV,
    CND_OUT
  } cond_t;

  // hold: stay on this step while the condition is false, else fall through
  typedef struct packed {
    uop_t  op;
    cond_t cond;
    logic  hold;
    step_t target;
  } ucode_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_ZCHK  = 3'd1;
  localparam step_t ST_LOOP  = 3'd2;
  localparam step_t ST_REM   = 3'd3;
  localparam step_t ST_QUOT  = 3'd4;
  localparam step_t ST_MUL   = 3'd5;
  localparam step_t ST_EMIT  = 3'd6;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      ST_IDLE: w = '{op: OP_ACCEPT, cond: CND_IN,     hold: 1'b1, target: ST_ZCHK};
      ST_ZCHK: w = '{op: OP_NOP,    cond: CND_ZERO,   hold: 1'b0, target: ST_EMIT};
      ST_LOOP: w = '{op: OP_NOP,    cond: CND_Y_ZERO, hold: 1'b0, target: ST_QUOT};
      ST_REM:  w = '{op: OP_DIV_XY, cond: CND_DIV,    hold: 1'b1, target: ST_LOOP};
      ST_QUOT: w = '{op: OP_DIV_AX, cond: CND_DIV,    hold: 1'b1, target: ST_MUL};
      ST_MUL:  w = '{op: OP_MUL,    cond: CND_ALWAYS, hold: 1'b1, target: ST_EMIT};
      ST_EMIT: w = '{op: OP_EMIT,   cond: CND_OUT,    hold: 1'b1, target: ST_IDLE};
      default: w = '{op: OP_NOP,    cond: CND_ALWAYS, hold: 1'b1, target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/lbe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_div: bit-serial unsigned divider
// restoring division, one quotient bit per cycle, done pulses for one cycle
// ----------------------------------------------------------------------------
module lbe_div
  import lbe_pkg::*;
#(
  parameter int WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CNT_WIDTH = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]     quo_r;
  logic [WIDTH-1:0]     rem_r;
  logic [WIDTH-1:0]     dvs_r;
  logic [CNT_WIDTH-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [WIDTH:0] shifted;
  logic [WIDTH:0] diff;
  logic           fits;

  assign shifted = {rem_r, quo_r[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_WIDTH'(WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_WIDTH'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[WIDTH-2:0], fits};
      rem_r <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/lcm_by_euclid.sv -----
// ----------------------------------------------------------------------------
// lcm_by_euclid: least common multiple of two unsigned operands
// a zero operand goes straight to the result; otherwise the sequencer runs
// k euclid remainder steps (each a serial division on the shared divider),
// then divides a by the gcd and multiplies by b; k reaches 46 at W = 32
// one transaction at a time: the next can be accepted in the cycle after the
// result registers; a waiting result does not block it; reset returns to idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lcm_by_euclid
  import lbe_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FIELD_WIDTH-1:0]    in_operand_a,
  input  logic [FIELD_WIDTH-1:0]    in_operand_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [MULTIPLE_WIDTH-1:0] out_multiple,
  output logic                      out_zero_operand
);

  localparam int W = OPERAND_WIDTH;

  step_t  pc_r;
  step_t  pc_nxt;
  ucode_t uc;
  logic   cond_met;

  logic [W-1:0]   a_r, b_r, x_r, y_r, q_r;
  logic [2*W-1:0] prod_r;
  logic           zero_r;
  logic           div_run_r;

  logic [MULTIPLE_WIDTH-1:0] out_multiple_r;
  logic                      out_zero_r;
  logic                      out_valid_r;

  logic [W-1:0] in_a, in_b;
  logic         div_start, div_done;
  logic [W-1:0] div_dividend, div_divisor, div_quo, div_rem;
  logic         is_div;
  logic         fire;

  assign in_a = in_operand_a[W-1:0];
  assign in_b = in_operand_b[W-1:0];

  assign uc = ucode_rom(pc_r);

  always_comb begin
    case (uc.cond)
      CND_ALWAYS: cond_met = 1'b1;
      CND_IN:     cond_met = in_valid;
      CND_ZERO:   cond_met = zero_r;
      CND_Y_ZERO: cond_met = (y_r == '0);
      CND_DIV:    cond_met = div_done;
      CND_OUT:    cond_met = !out_valid_r || out_ready;
      default:    cond_met = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_met) begin
      pc_nxt = uc.target;
    end else if (uc.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  // a step's op acts in the cycle its condition is met
  assign fire = cond_met;

  assign is_div       = (uc.op == OP_DIV_XY) || (uc.op == OP_DIV_AX);
  assign div_start    = is_div && !div_run_r;
  assign div_dividend = (uc.op == OP_DIV_XY) ? x_r : a_r;
  assign div_divisor  = x_r;

  lbe_div #(
    .WIDTH (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   ((uc.op == OP_DIV_XY) ? y_r : div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (div_start) begin
        div_run_r <= 1'b1;
      end else if (div_done) begin
        div_run_r <= 1'b0;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (uc.op == OP_EMIT && fire) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // datapath, steered by the current control word
  always_ff @(posedge clk) begin
    case (uc.op)
      OP_ACCEPT: begin
        if (fire) begin
          a_r    <= in_a;
          b_r    <= in_b;
          x_r    <= in_a;
          y_r    <= in_b;
          prod_r <= '0;
          zero_r <= (in_a == '0) || (in_b == '0);
        end
      end
      OP_DIV_XY: begin
        if (fire) begin
          x_r <= y_r;
          y_r <= div_rem;
        end
      end
      OP_DIV_AX: begin
        if (fire) begin
          q_r <= div_quo;
        end
      end
      OP_MUL: begin
        prod_r <= (2*W)'(q_r) * (2*W)'(b_r);
      end
      OP_EMIT: begin
        if (fire) begin
          out_multiple_r <= MULTIPLE_WIDTH'(prod_r);
          out_zero_r     <= zero_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready         = (uc.cond == CND_IN);
  assign out_valid        = out_valid_r;
  assign out_multiple     = out_multiple_r;
  assign out_zero_operand = out_zero_r;

endmodule
